// ===== rtl/core/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg: shared definitions for the Gregorian date adder
// Widths, calendar constants, month length lookup and the types that pass
// between the sequencer and the shared add/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

   // Day count: day (31) + offset (65535) + up to 335 days of earlier months
   localparam int ALU_WIDTH  = 17;
   // Internal year: 14-bit start year plus roughly two centuries of roll-over
   localparam int YEAR_WIDTH = 15;

   localparam int YEAR_CYCLE = 400;
   localparam int CENTURY    = 100;
   localparam int MONTHS     = 12;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type             op;
      logic [ALU_WIDTH-1:0]   a;
      logic [ALU_WIDTH-1:0]   b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_WIDTH-1:0]   result;
      logic                   a_gt_b;
      logic                   a_lt_b;
   } alu_rsp_type;

   // Days in a month; February follows the leap flag
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      unique case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gda_if.sv =====
// ----------------------------------------------------------------------------
// gda_if: request and response channels of the Gregorian date adder
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gda_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] start_year;
   logic [3:0]  start_month;
   logic [4:0]  start_day;
   logic [15:0] days_to_add;

   modport source (output valid, start_year, start_month, start_day, days_to_add,
                   input ready);
   modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                   output ready);
endinterface

interface gda_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] result_year;
   logic [3:0]  result_month;
   logic [4:0]  result_day;

   modport source (output valid, result_year, result_month, result_day,
                   input ready);
   modport sink   (input valid, result_year, result_month, result_day,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gda_alu.sv =====
// ----------------------------------------------------------------------------
// gda_alu: shared add/subtract and compare unit
// One adder and one magnitude compare, reused by every sequencer step.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_alu (
   input  gda_pkg::alu_req_type alu_req,
   output gda_pkg::alu_rsp_type alu_rsp
);

   // Add or subtract, compare operands
   always_comb begin
      unique case (alu_req.op)
         gda_pkg::ALU_ADD: alu_rsp.result = alu_req.a + alu_req.b;
         gda_pkg::ALU_SUB: alu_rsp.result = alu_req.a - alu_req.b;
         default:          alu_rsp.result = alu_req.a + alu_req.b;
      endcase
      alu_rsp.a_gt_b = (alu_req.a > alu_req.b);
      alu_rsp.a_lt_b = (alu_req.a < alu_req.b);
   end

endmodule

`default_nettype wire

// ===== rtl/core/gda_seq.sv =====
// ----------------------------------------------------------------------------
// gda_seq: step sequencer of the Gregorian date adder
// Reduces the year modulo 400, builds the day-of-year count, then walks
// months forward one per cycle through the shared add/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_seq (
   input  wire                   clock,
   input  wire                   reset,
   gda_req_if.sink               req_ch,
   gda_rsp_if.source             rsp_ch,
   output gda_pkg::alu_req_type  alu_req,
   input  gda_pkg::alu_rsp_type  alu_rsp
);

   localparam int AW = gda_pkg::ALU_WIDTH;
   localparam int YW = gda_pkg::YEAR_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MOD  = 4'b0010,
      ST_PRE  = 4'b0100,
      ST_WALK = 4'b1000
   } state_type;

   state_type         state_ff,     state_in;
   logic [YW-1:0]     year_ff,      year_in;
   logic [YW-1:0]     ymod_ff,      ymod_in;
   logic [3:0]        mon_ff,       mon_in;
   logic [3:0]        tgt_ff,       tgt_in;
   logic [AW-1:0]     rem_ff,       rem_in;
   logic              out_valid_ff, out_valid_in;
   logic [13:0]       out_year_ff,  out_year_in;
   logic [3:0]        out_month_ff, out_month_in;
   logic [4:0]        out_day_ff,   out_day_in;

   logic              leap;
   logic [4:0]        len;
   logic [3:0]        month_clamp;
   logic [4:0]        day_norm;
   logic              out_free;
   logic              accept;

   // Leap rule from the year residue modulo 400 and the low year bits
   assign leap = (ymod_ff == '0) ||
                 ((year_ff[1:0] == 2'b00) &&
                  (ymod_ff != YW'(gda_pkg::CENTURY)) &&
                  (ymod_ff != YW'(2 * gda_pkg::CENTURY)) &&
                  (ymod_ff != YW'(3 * gda_pkg::CENTURY)));

   assign len = gda_pkg::month_days(mon_ff, leap);

   // Clamp month and day of the incoming item
   always_comb begin
      priority if (req_ch.start_month == 4'd0) begin
         month_clamp = gda_pkg::MONTH_JAN;
      end else if (req_ch.start_month > gda_pkg::MONTH_DEC) begin
         month_clamp = gda_pkg::MONTH_DEC;
      end else begin
         month_clamp = req_ch.start_month;
      end
   end
   assign day_norm = (req_ch.start_day == 5'd0) ? 5'd1 : req_ch.start_day;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   // Drive the shared unit for the current step
   always_comb begin
      alu_req.op = gda_pkg::ALU_ADD;
      alu_req.a  = rem_ff;
      alu_req.b  = AW'(len);
      unique case (state_ff)
         ST_IDLE: begin
            alu_req.op = gda_pkg::ALU_ADD;
            alu_req.a  = AW'(req_ch.days_to_add);
            alu_req.b  = AW'(day_norm);
         end
         ST_MOD: begin
            alu_req.op = gda_pkg::ALU_SUB;
            alu_req.a  = AW'(ymod_ff);
            alu_req.b  = AW'(gda_pkg::YEAR_CYCLE);
         end
         ST_PRE: begin
            alu_req.op = gda_pkg::ALU_ADD;
         end
         ST_WALK: begin
            alu_req.op = gda_pkg::ALU_SUB;
         end
         default: begin
            alu_req.op = gda_pkg::ALU_ADD;
         end
      endcase
   end

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      ymod_in      = ymod_ff;
      mon_in       = mon_ff;
      tgt_in       = tgt_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               year_in  = YW'(req_ch.start_year);
               ymod_in  = YW'(req_ch.start_year);
               tgt_in   = month_clamp;
               mon_in   = gda_pkg::MONTH_JAN;
               rem_in   = alu_rsp.result;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // Strip whole 400-year cycles
            if (!alu_rsp.a_lt_b) begin
               ymod_in = alu_rsp.result[YW-1:0];
            end else begin
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            // Add lengths of months before the start month
            if (mon_ff < tgt_ff) begin
               rem_in = alu_rsp.result;
               mon_in = mon_ff + 4'd1;
            end else begin
               mon_in   = gda_pkg::MONTH_JAN;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // Consume one month per cycle, roll into the next year after December
            if (alu_rsp.a_gt_b) begin
               rem_in = alu_rsp.result;
               if (mon_ff == gda_pkg::MONTH_DEC) begin
                  mon_in  = gda_pkg::MONTH_JAN;
                  year_in = year_ff + YW'(1);
                  ymod_in = (ymod_ff == YW'(gda_pkg::YEAR_CYCLE - 1)) ? '0
                                                                     : ymod_ff + YW'(1);
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_year_in  = year_ff[13:0];
               out_month_in = mon_ff;
               out_day_in   = rem_ff[4:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      ymod_ff      <= ymod_in;
      mon_ff       <= mon_in;
      tgt_ff       <= tgt_in;
      rem_ff       <= rem_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_year  = out_year_ff;
   assign rsp_ch.result_month = out_month_ff;
   assign rsp_ch.result_day   = out_day_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gregorian_date_add_days_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top: add a day count to a Gregorian date
// Request: start year, month, day and days to add. Response: resulting
// year, month and day. Month 0 reads as January, above 12 as December,
// day 0 as day 1; a day past its month's end rolls into later months.
//
// Usage and timing:
//   - req_ch is ready only while the sequencer is idle; one item at a time.
//   - After accept, the sequencer strips whole 400-year cycles from the start
//     year, adds the lengths of the months before the start month, then
//     walks months forward on the shared add/compare unit: one month per
//     cycle, up to about 2165 months for the largest offset.
//   - A new item is taken only after the last one is done: req_ch becomes ready
//     again on the same clock edge that loads the result into the output register.
//   - The result sits in an output register; a new item is accepted while
//     it waits. If rsp_ch stalls, the next result is held in the final
//     walk step until the output register frees up.
//   - Synchronous reset returns the sequencer to idle and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days_top (
   input  wire        clock,
   input  wire        reset,
   gda_req_if.sink    req_ch,
   gda_rsp_if.source  rsp_ch
);

   gda_pkg::alu_req_type alu_req;
   gda_pkg::alu_rsp_type alu_rsp;

   gda_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   gda_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

`ifndef SYNTHESIS
   // Busy after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request ready right after accept");

   // Result month in calendar range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.result_month >= 4'd1 && rsp_ch.result_month <= 4'd12))
      else $error("result month out of range");

   // Result day is not zero
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.result_day != 5'd0))
      else $error("result day is zero");
`endif

endmodule

`default_nettype wire
